>>> sv/fra_pkg.sv
// Package for the fraction arithmetic block: field widths, opcode and status
// codes, sequencer states and the transfer payload structs.
// No dependencies.
package fra_pkg;

  localparam int OPERAND_BITS_DEF = 16;  // default operand width
  localparam int FIELD_W          = 16;  // width of each input operand field
  localparam int RES_NUM_W        = 33;
  localparam int RES_DEN_W        = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } fra_op_e;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_ZERO = 1'b1
  } fra_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,  // waiting for an input transfer
    ST_MA,    // first product issued
    ST_MB,    // first product back, second issued
    ST_MC,    // add/sub: cross product back, accumulate, denominator issued
    ST_MD,    // denominator product back
    ST_CHK,   // both-zero check, Euclid setup
    ST_LOOP,  // Euclid test, starts a remainder or the numerator quotient
    ST_GCD,   // waiting on x % y
    ST_DIVN,  // waiting on num / g
    ST_DIVD,  // waiting on den / g
    ST_WR     // loading the output register
  } fra_state_e;

  typedef struct packed {
    fra_op_e            opcode;
    logic signed [15:0] num_a;
    logic signed [15:0] den_a;
    logic signed [15:0] num_b;
    logic signed [15:0] den_b;
  } fra_in_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] res_num;
    logic signed [RES_DEN_W-1:0] res_den;
    fra_status_e                 status;
  } fra_out_t;

endpackage

>>> sv/fraction_arith_reduce.sv
// Sequence: products (two for multiply/divide, three for add/subtract) and zero check,
// then Euclid remainder steps and the two quotients on the shared divider, then the
// output load; W = 2*OPERAND_BITS+1 is the working width. 0/0 skips to the load.
// One item at a time: in_stall_o drops the cycle after the output load; a stalled
// result holds the load.
// Async active-low rst_ni idles the sequencer, drops out_valid_o. Uses fra_pkg/mul/div.
module fraction_arith_reduce #(
  parameter int OPERAND_BITS = fra_pkg::OPERAND_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fra_pkg::fra_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fra_pkg::fra_out_t out_data_o
);

  localparam int OB  = OPERAND_BITS;
  localparam int PW  = 2 * OB;       // product width
  localparam int W   = 2 * OB + 1;   // numerator / Euclid working width
  localparam int NW  = fra_pkg::RES_NUM_W;
  localparam int DW  = fra_pkg::RES_DEN_W;
  localparam int FW  = fra_pkg::FIELD_W;

  fra_pkg::fra_state_e state_q, state_d;

  // ---------------------------------------------------------------------
  // Operand capture: each field narrowed to OB bits, kept as sign/magnitude
  // ---------------------------------------------------------------------
  logic [FW-1:0]  fld   [4];
  logic [OB-1:0]  raw   [4];
  logic [OB-1:0]  mag_in[4];
  logic           neg_in[4];
  logic [OB+FW-1:0] ext [4];

  assign fld[0] = in_data_i.num_a;
  assign fld[1] = in_data_i.den_a;
  assign fld[2] = in_data_i.num_b;
  assign fld[3] = in_data_i.den_b;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ext[i]    = {{OB{1'b0}}, fld[i]};
      raw[i]    = ext[i][OB-1:0];
      neg_in[i] = raw[i][OB-1];
      mag_in[i] = neg_in[i] ? OB'(-raw[i]) : raw[i];
    end
  end

  fra_pkg::fra_op_e op_q;
  logic          a_neg_q, b_neg_q, c_neg_q, d_neg_q;
  logic [OB-1:0] a_mag_q, b_mag_q, c_mag_q, d_mag_q;

  // unreduced fraction and Euclid pair
  logic         num_neg_q, den_neg_q, x_neg_q, y_neg_q;
  logic [W-1:0] num_mag_q, den_mag_q, x_mag_q, y_mag_q;
  logic [W-1:0] rn_mag_q;
  logic         err_q;

  logic      in_xfer;
  logic      out_load;
  assign in_xfer = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------
  // Shared multiplier
  // ---------------------------------------------------------------------
  logic          mul_en;
  logic          mx_neg, my_neg, p_neg;
  logic [OB-1:0] mx_mag, my_mag;
  logic [PW-1:0] p_mag;

  fra_mul #(.OPERAND_BITS(OB)) u_mul (
    .clk_i   (clk_i),
    .en_i    (mul_en),
    .x_neg_i (mx_neg),
    .x_mag_i (mx_mag),
    .y_neg_i (my_neg),
    .y_mag_i (my_mag),
    .p_neg_o (p_neg),
    .p_mag_o (p_mag)
  );

  // ---------------------------------------------------------------------
  // Shared divider: Euclid remainders and both final quotients
  // ---------------------------------------------------------------------
  logic         div_start, div_done;
  logic [W-1:0] div_n, div_d, div_quo, div_rem;

  fra_div #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  logic addsub;
  assign addsub = (op_q == fra_pkg::OP_ADD) || (op_q == fra_pkg::OP_SUB);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fra_pkg::ST_IDLE: if (in_xfer) state_d = fra_pkg::ST_MA;
      fra_pkg::ST_MA:   state_d = fra_pkg::ST_MB;
      fra_pkg::ST_MB:   state_d = addsub ? fra_pkg::ST_MC : fra_pkg::ST_MD;
      fra_pkg::ST_MC:   state_d = fra_pkg::ST_MD;
      fra_pkg::ST_MD:   state_d = fra_pkg::ST_CHK;
      fra_pkg::ST_CHK: begin
        if (num_mag_q == '0 && den_mag_q == '0) state_d = fra_pkg::ST_WR;
        else                                    state_d = fra_pkg::ST_LOOP;
      end
      fra_pkg::ST_LOOP: state_d = (y_mag_q == '0) ? fra_pkg::ST_DIVN : fra_pkg::ST_GCD;
      fra_pkg::ST_GCD:  if (div_done) state_d = fra_pkg::ST_LOOP;
      fra_pkg::ST_DIVN: if (div_done) state_d = fra_pkg::ST_DIVD;
      fra_pkg::ST_DIVD: if (div_done) state_d = fra_pkg::ST_WR;
      fra_pkg::ST_WR:   if (out_load) state_d = fra_pkg::ST_IDLE;
      default:          state_d = fra_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer outputs: unit operand selects and strobes
  // ---------------------------------------------------------------------
  always_comb begin
    in_stall_o = 1'b1;
    mul_en     = 1'b0;
    mx_neg     = a_neg_q;
    mx_mag     = a_mag_q;
    my_neg     = d_neg_q;
    my_mag     = d_mag_q;
    div_start  = 1'b0;
    div_n      = x_mag_q;
    div_d      = y_mag_q;
    out_load   = 1'b0;
    unique case (state_q)
      fra_pkg::ST_IDLE: in_stall_o = 1'b0;
      fra_pkg::ST_MA: begin
        // numerator term a*d, or a*c for multiply
        mul_en = 1'b1;
        if (op_q == fra_pkg::OP_MUL) begin
          my_neg = c_neg_q;
          my_mag = c_mag_q;
        end
      end
      fra_pkg::ST_MB: begin
        mul_en = 1'b1;
        if (addsub) begin
          mx_neg = c_neg_q;  mx_mag = c_mag_q;
          my_neg = b_neg_q;  my_mag = b_mag_q;
        end else begin
          mx_neg = b_neg_q;  mx_mag = b_mag_q;
          if (op_q == fra_pkg::OP_DIV) begin
            my_neg = c_neg_q;  my_mag = c_mag_q;
          end
        end
      end
      fra_pkg::ST_MC: begin
        mul_en = 1'b1;
        mx_neg = b_neg_q;
        mx_mag = b_mag_q;
      end
      fra_pkg::ST_LOOP: begin
        div_start = 1'b1;
        if (y_mag_q == '0) begin
          // x now holds g
          div_n = num_mag_q;
          div_d = x_mag_q;
        end
      end
      fra_pkg::ST_DIVN: begin
        div_start = div_done;
        div_n     = den_mag_q;
        div_d     = x_mag_q;
      end
      fra_pkg::ST_WR: out_load = !out_valid_o || !out_stall_i;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sign-magnitude accumulate for add/subtract
  // ---------------------------------------------------------------------
  logic         q_neg, s_neg;
  logic [W-1:0] q_mag, s_mag;

  always_comb begin
    q_mag = W'(p_mag);
    q_neg = (op_q == fra_pkg::OP_SUB && p_mag != '0) ? !p_neg : p_neg;
    if (num_neg_q == q_neg) begin
      s_mag = num_mag_q + q_mag;
      s_neg = num_neg_q;
    end else if (num_mag_q >= q_mag) begin
      s_mag = num_mag_q - q_mag;
      s_neg = num_neg_q;
    end else begin
      s_mag = q_mag - num_mag_q;
      s_neg = q_neg;
    end
    if (s_mag == '0) s_neg = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Result formatting: quotient signs follow g, wrapped to field widths
  // ---------------------------------------------------------------------
  logic            rn_neg, rd_neg;
  logic [W+NW-1:0] rn_ext;
  logic [W+DW-1:0] rd_ext;
  fra_pkg::fra_out_t res;

  always_comb begin
    rn_neg = (rn_mag_q != '0) && (num_neg_q != x_neg_q);
    rd_neg = (div_quo != '0) && (den_neg_q != x_neg_q);
    rn_ext = {{NW{1'b0}}, rn_mag_q};
    rd_ext = {{DW{1'b0}}, div_quo};
    if (rn_neg) rn_ext = -rn_ext;
    if (rd_neg) rd_ext = -rd_ext;
    if (err_q) begin
      res.res_num = '0;
      res.res_den = '0;
      res.status  = fra_pkg::STATUS_ZERO;
    end else begin
      res.res_num = rn_ext[NW-1:0];
      res.res_den = rd_ext[DW-1:0];
      res.status  = fra_pkg::STATUS_OK;
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  logic out_valid_q;
  fra_pkg::fra_out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fra_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)          out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= in_data_i.opcode;
      a_neg_q <= neg_in[0];  a_mag_q <= mag_in[0];
      b_neg_q <= neg_in[1];  b_mag_q <= mag_in[1];
      c_neg_q <= neg_in[2];  c_mag_q <= mag_in[2];
      d_neg_q <= neg_in[3];  d_mag_q <= mag_in[3];
    end
    unique case (state_q)
      fra_pkg::ST_MB: begin
        num_mag_q <= W'(p_mag);
        num_neg_q <= p_neg;
        den_mag_q <= W'(p_mag);  // overwritten in ST_MD for every opcode
        den_neg_q <= p_neg;
      end
      fra_pkg::ST_MC: begin
        num_mag_q <= s_mag;
        num_neg_q <= s_neg;
      end
      fra_pkg::ST_MD: begin
        den_mag_q <= W'(p_mag);
        den_neg_q <= p_neg;
      end
      fra_pkg::ST_CHK: begin
        err_q   <= (num_mag_q == '0) && (den_mag_q == '0);
        x_mag_q <= num_mag_q;
        x_neg_q <= num_neg_q;
        y_mag_q <= den_mag_q;
        y_neg_q <= den_neg_q;
      end
      fra_pkg::ST_GCD: begin
        if (div_done) begin
          // truncating remainder takes the dividend's sign
          x_mag_q <= y_mag_q;
          x_neg_q <= y_neg_q;
          y_mag_q <= div_rem;
          y_neg_q <= x_neg_q;
        end
      end
      fra_pkg::ST_DIVN: if (div_done) rn_mag_q <= div_quo;
      default: ;
    endcase
    if (out_load) out_data_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> sv/fra_mul.sv
// Shared sign-magnitude multiplier with a registered product.
// Depends on nothing but its parameter.
module fra_mul #(
  parameter int OPERAND_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic                      x_neg_i,
  input  logic [OPERAND_BITS-1:0]   x_mag_i,
  input  logic                      y_neg_i,
  input  logic [OPERAND_BITS-1:0]   y_mag_i,
  output logic                      p_neg_o,
  output logic [2*OPERAND_BITS-1:0] p_mag_o
);

  logic                      p_neg_q;
  logic [2*OPERAND_BITS-1:0] p_mag_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_mag_q <= (2*OPERAND_BITS)'(x_mag_i) * (2*OPERAND_BITS)'(y_mag_i);
      // zero product carries no sign
      p_neg_q <= (x_neg_i != y_neg_i) && (x_mag_i != '0) && (y_mag_i != '0);
    end
  end

  assign p_neg_o = p_neg_q;
  assign p_mag_o = p_mag_q;

endmodule

>>> sv/fra_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Gives quotient and truncating remainder; no package dependency.
module fra_div #(
  parameter int W = 33
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);

  localparam int CW = $clog2(W + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  quo_q, rem_q, dvs_q;
  logic [W:0]    shifted;
  logic [W+1:0]  diff;
  logic          fits;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = !diff[W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[W-1:0] : shifted[W-1:0];
      quo_q <= {quo_q[W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> sv/fra_chk.sv
// Port-level checker for fraction_arith_reduce, bound to the top level.
// Depends on fra_pkg.
module fra_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input fra_pkg::fra_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input fra_pkg::fra_out_t out_data_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one item in flight: input stalls right after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input taken while busy");

  // no result can appear the cycle after an accept
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_o))
    else $error("result too early");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == fra_pkg::STATUS_ZERO |->
      out_data_o.res_num == '0 && out_data_o.res_den == '0)
    else $error("error result not zero");

  // good results are never 0/0
  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == fra_pkg::STATUS_OK |->
      out_data_o.res_num != '0 || out_data_o.res_den != '0)
    else $error("ok result is 0/0");

endmodule

bind fraction_arith_reduce fra_chk u_fra_chk (.*);

>>> bench/tb.sv
// Self-checking bench for fraction_arith_reduce: a directed table followed by
// random fraction pairs; each result is checked against a predictor or a typed row.
// Depends on fra_pkg and the fraction_arith_reduce RTL.
`timescale 1ns / 100ps

module tb;
  import fra_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_CYCLES = 2500;  // worst case Euclid plus two quotients

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  fra_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  fra_out_t out_data_o;

  fraction_arith_reduce dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #100_000_000;
    $display("tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: sign and magnitude arithmetic, so nothing can overflow.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } smag_t;

  function automatic smag_t as_smag(logic [15:0] raw);
    smag_t r;
    r.neg = raw[15];
    r.mag = raw[15] ? {48'b0, 16'(~raw + 16'd1)} : {48'b0, raw};
    return r;
  endfunction

  function automatic smag_t smag_mul(smag_t x, smag_t y);
    smag_t r;
    r.mag = x.mag * y.mag;
    r.neg = (r.mag != 0) && (x.neg != y.neg);
    return r;
  endfunction

  function automatic smag_t smag_add(smag_t x, smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic fra_out_t reduce_fraction(fra_in_t it);
    smag_t       a, b, c, d, num, den, x, y, cb;
    logic [63:0] rem, qn, qd, un, ud;
    logic        tneg;
    fra_out_t    r;
    a = as_smag(it.num_a);
    b = as_smag(it.den_a);
    c = as_smag(it.num_b);
    d = as_smag(it.den_b);
    case (it.opcode)
      OP_ADD: begin
        num = smag_add(smag_mul(a, d), smag_mul(c, b));
        den = smag_mul(b, d);
      end
      OP_SUB: begin
        cb = smag_mul(c, b);
        if (cb.mag != 0) cb.neg = ~cb.neg;
        num = smag_add(smag_mul(a, d), cb);
        den = smag_mul(b, d);
      end
      OP_MUL: begin
        num = smag_mul(a, c);
        den = smag_mul(b, d);
      end
      default: begin
        num = smag_mul(a, d);
        den = smag_mul(b, c);
      end
    endcase
    r = '0;
    if (num.mag == 0 && den.mag == 0) begin
      r.status = STATUS_ZERO;
      return r;
    end
    // Truncating remainder keeps the dividend's sign, so signs swap each step
    // and g may come out negative.
    x = num;
    y = den;
    while (y.mag != 0) begin
      rem   = x.mag % y.mag;
      tneg  = x.neg;
      x     = y;
      y.mag = rem;
      y.neg = tneg;
    end
    qn = num.mag / x.mag;
    qd = den.mag / x.mag;
    un = ((qn != 0) && (num.neg != x.neg)) ? -qn : qn;
    ud = ((qd != 0) && (den.neg != x.neg)) ? -qd : qd;
    r.res_num = un[RES_NUM_W-1:0];
    r.res_den = ud[RES_DEN_W-1:0];
    r.status  = STATUS_OK;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Rows with typed set carry a hand-written result.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    fra_op_e                     op;
    logic signed [15:0]          a, b, c, d;
    logic                        typed;
    logic signed [RES_NUM_W-1:0] rn;
    logic signed [RES_DEN_W-1:0] rd;
    fra_status_e                 st;
  } dir_row_t;

  localparam int DIR_ROWS = 20;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // both unreduced terms zero: error flag, zero fields
    '{OP_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 33'sd0, 32'sd0, STATUS_ZERO},
    '{OP_SUB, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 33'sd0, 32'sd0, STATUS_ZERO},
    '{OP_MUL, 16'sd0, 16'sd0, 16'sd5, 16'sd0, 1'b1, 33'sd0, 32'sd0, STATUS_ZERO},
    '{OP_DIV, 16'sd5, 16'sd0, 16'sd7, 16'sd0, 1'b1, 33'sd0, 32'sd0, STATUS_ZERO},
    // zero numerator reduces to 0/1, zero denominator to 1/0
    '{OP_DIV, 16'sd0, 16'sd7, 16'sd3, 16'sd0, 1'b1, 33'sd0, 32'sd1, STATUS_OK},
    '{OP_MUL, 16'sd0, -16'sd3, 16'sd4, 16'sd5, 1'b1, 33'sd0, 32'sd1, STATUS_OK},
    '{OP_MUL, 16'sd3, 16'sd0, 16'sd2, 16'sd5, 1'b1, 33'sd1, 32'sd0, STATUS_OK},
    '{OP_MUL, -16'sd3, 16'sd0, 16'sd2, 16'sd5, 1'b1, 33'sd1, 32'sd0, STATUS_OK},
    // most negative operand squared
    '{OP_MUL, -16'sd32768, 16'sd1, -16'sd32768, 16'sd1, 1'b1,
      33'sd1073741824, 32'sd1, STATUS_OK},
    // the rest are predicted
    '{OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b0, 33'sd0, 32'sd0, STATUS_OK},
    '{OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b0, 33'sd0, 32'sd0, STATUS_OK},
    '{OP_MUL, -16'sd1, 16'sd1, 16'sd2, 16'sd4, 1'b0, 33'sd0, 32'sd0, STATUS_OK},
    '{OP_DIV, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b0,
      33'sd0, 32'sd0, STATUS_OK},
    '{OP_ADD, -16'sd32768, 16'sd32767, -16'sd32768, -16'sd32767, 1'b0,
      33'sd0, 32'sd0, STATUS_OK},
    '{OP_SUB, 16'sd32767, -16'sd1, -16'sd32768, -16'sd1, 1'b0,
      33'sd0, 32'sd0, STATUS_OK},
    '{OP_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, 33'sd0, 32'sd0, STATUS_OK},
    '{OP_MUL, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0,
      33'sd0, 32'sd0, STATUS_OK},
    '{OP_DIV, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0,
      33'sd0, 32'sd0, STATUS_OK},
    '{OP_ADD, 16'sd21845, -16'sd21846, -16'sd21846, 16'sd21845, 1'b0,
      33'sd0, 32'sd0, STATUS_OK},
    '{OP_SUB, -16'sd21846, 16'sd21845, 16'sd21845, -16'sd21846, 1'b0,
      33'sd0, 32'sd0, STATUS_OK}
  };

  fra_out_t pending_results [$];
  int       errors = 0;
  bit       in_quiet = 1'b0;
  bit       out_quiet = 1'b0;

  // Half are small values so reductions and zero cases are frequent; some full
  // range for every bit, some corner values.
  function automatic logic [15:0] pick_operand();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 16'($signed($urandom_range(0, 40)) - 20);
    if (sel < 8) return 16'($urandom);
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return 16'h7FFF;
      default: return 16'h8000;
    endcase
  endfunction

  // One input transfer: optional gap, then hold valid until stall drops.
  task automatic send_item(input fra_in_t item, input logic typed,
                           input fra_out_t typed_res);
    int gap;
    if ($urandom_range(0, 15) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  = item;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(typed ? typed_res : reduce_fraction(item));
    @(negedge clk_i);
  endtask

  // Output side: random stall before each result, stretches with none.
  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) out_quiet = !out_quiet;
      gap = out_quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_stall_i = 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Result checker: each output transfer against the oldest expectation.
  always @(posedge clk_i) begin
    fra_out_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result num %0d den %0d status %0d", $time,
                 out_data_o.res_num, out_data_o.res_den, out_data_o.status);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data_o.res_num !== exp_res.res_num) begin
          $display("%0t res_num expected %0d got %0d", $time,
                   exp_res.res_num, out_data_o.res_num);
          errors++;
        end
        if (out_data_o.res_den !== exp_res.res_den) begin
          $display("%0t res_den expected %0d got %0d", $time,
                   exp_res.res_den, out_data_o.res_den);
          errors++;
        end
        if (out_data_o.status !== exp_res.status) begin
          $display("%0t status expected %0d got %0d", $time,
                   exp_res.status, out_data_o.status);
          errors++;
        end
      end
    end
  end

  initial begin
    fra_in_t  item;
    fra_out_t typed_res;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      item.opcode = directed_rows[i].op;
      item.num_a  = directed_rows[i].a;
      item.den_a  = directed_rows[i].b;
      item.num_b  = directed_rows[i].c;
      item.den_b  = directed_rows[i].d;
      typed_res.res_num = directed_rows[i].rn;
      typed_res.res_den = directed_rows[i].rd;
      typed_res.status  = directed_rows[i].st;
      send_item(item, directed_rows[i].typed, typed_res);
    end

    typed_res = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      item.opcode = fra_op_e'($urandom_range(0, 3));
      item.num_a  = pick_operand();
      item.den_a  = pick_operand();
      item.num_b  = pick_operand();
      item.den_b  = pick_operand();
      send_item(item, 1'b0, typed_res);
    end
    in_valid_i = 1'b0;

    // Drain, then idle long enough to catch any stray output.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
